FILE: hdl/fmtc_pkg.sv
package fmtc_pkg;

  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_ON      = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;

  localparam logic [1:0] CFG_SPIN_UP   = 2'd0;
  localparam logic [1:0] CFG_OFF_DELAY = 2'd1;
  localparam logic [1:0] CFG_HOLD      = 2'd2;

  localparam logic [15:0] SPIN_UP_RESET   = 16'd50;
  localparam logic [15:0] OFF_DELAY_RESET = 16'd300;
  localparam logic [15:0] HOLD_RESET      = 16'd10000;

  localparam logic [7:0]  MOTOR_BASE    = 8'h10;
  localparam logic [7:0]  MOTOR_BITS    = 8'hF0;
  localparam logic [7:0]  SELECT_CLEAR  = 8'hFC;
  localparam logic [7:0]  CONTROL_RESET = 8'h0C;
  localparam logic [15:0] MIN_SPIN      = 16'd2;

  typedef struct packed {
    logic tick;
    logic on;
    logic rel;
    logic spin_load;
    logic spin_raise;
  } drv_ctrl_t;

  typedef struct packed {
    logic [15:0] spin_nxt;
    logic        wake;
    logic        stop;
  } drv_stat_t;

endpackage

FILE: hdl/fmtc_drive.sv
module fmtc_drive (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  fmtc_pkg::drv_ctrl_t ctrl,
  input  logic [15:0]       spin_up,
  input  logic [15:0]       off_delay,
  input  logic [15:0]       hold,
  output fmtc_pkg::drv_stat_t stat
);

  logic [15:0] spin_r, spin_nxt;
  logic [15:0] off_r, off_nxt;
  logic        spin_zero, off_zero;

  always_comb begin
    spin_zero = (spin_r == 16'd0);
    off_zero  = (off_r == 16'd0);
    if (ctrl.spin_load) begin
      spin_nxt = spin_up;
    end else if (ctrl.spin_raise && (spin_r < fmtc_pkg::MIN_SPIN)) begin
      spin_nxt = fmtc_pkg::MIN_SPIN;
    end else if (ctrl.tick && !spin_zero) begin
      spin_nxt = spin_r - 16'd1;
    end else begin
      spin_nxt = spin_r;
    end
    if (ctrl.on) begin
      off_nxt = hold;
    end else if (ctrl.rel) begin
      off_nxt = off_delay;
    end else if (ctrl.tick && spin_zero && !off_zero) begin
      off_nxt = off_r - 16'd1;
    end else begin
      off_nxt = off_r;
    end
    stat.spin_nxt = spin_nxt;
    stat.wake     = ctrl.tick && (spin_r == 16'd1);
    stat.stop     = ctrl.tick && spin_zero && off_zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spin_r <= 16'd0;
      off_r  <= 16'd0;
    end else if (en) begin
      spin_r <= spin_nxt;
      off_r  <= off_nxt;
    end
  end

endmodule

FILE: hdl/floppy_motor_timer_controller.sv
// floppy motor on/off timer
// the result of an accepted request is held in the output register from the next cycle
// throughput: one request per cycle while out_ready is high; a new request is taken while the result is taken
// all per-drive counters update in parallel in the accept cycle
// reset (synchronous, active low): control byte 0x0C, counters 0, registers 50/300/10000
module floppy_motor_timer_controller #(
  parameter int DRIVES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [1:0]  in_drive,
  input  logic        in_drive_selected,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_control_byte,
  output logic        out_control_written,
  output logic [3:0]  out_wake_mask,
  output logic [15:0] out_ready_ticks,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [15:0] spin_up_r, off_delay_r, hold_r;
  logic [7:0]  ctrl_r, ctrl_nxt;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_written_r;
  logic [3:0]  out_wake_r;
  logic [15:0] out_ticks_r;

  logic        accept;
  logic        cmd_tick, cmd_on, cmd_rel, drive_ok;
  logic [7:0]  on_byte, stop_bits;
  logic        on_changed, motor_changed;
  logic        written;
  logic [3:0]  wake;
  logic [15:0] ready_ticks;

  fmtc_pkg::drv_ctrl_t drv_ctrl [DRIVES];
  fmtc_pkg::drv_stat_t drv_stat [DRIVES];

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    drive_ok = ({1'b0, in_drive} < 3'(DRIVES));
    cmd_tick = (in_command == fmtc_pkg::CMD_TICK);
    cmd_on   = (in_command == fmtc_pkg::CMD_ON) && drive_ok;
    cmd_rel  = (in_command == fmtc_pkg::CMD_RELEASE) && drive_ok;
    on_byte  = ctrl_r | (fmtc_pkg::MOTOR_BASE << in_drive);
    if (!in_drive_selected) begin
      on_byte = (on_byte & fmtc_pkg::SELECT_CLEAR) | {6'd0, in_drive};
    end
    on_changed    = (on_byte != ctrl_r);
    motor_changed = |((on_byte ^ ctrl_r) & fmtc_pkg::MOTOR_BITS);
    stop_bits   = 8'd0;
    wake        = 4'd0;
    ready_ticks = 16'd0;
    for (int i = 0; i < DRIVES; i++) begin
      drv_ctrl[i].tick       = cmd_tick && ctrl_r[4 + i];
      drv_ctrl[i].on         = cmd_on && (in_drive == 2'(i));
      drv_ctrl[i].rel        = cmd_rel && (in_drive == 2'(i));
      drv_ctrl[i].spin_load  = drv_ctrl[i].on && on_changed && motor_changed;
      drv_ctrl[i].spin_raise = drv_ctrl[i].on && on_changed && !motor_changed;
      stop_bits[4 + i] = drv_stat[i].stop;
      wake[i]          = drv_stat[i].wake;
      if (drv_ctrl[i].on) begin
        ready_ticks = drv_stat[i].spin_nxt;
      end
    end
    if (cmd_tick) begin
      ctrl_nxt = ctrl_r & ~stop_bits;
      written  = |stop_bits;
    end else if (cmd_on && on_changed) begin
      ctrl_nxt = on_byte;
      written  = 1'b1;
    end else begin
      ctrl_nxt = ctrl_r;
      written  = 1'b0;
    end
  end

  for (genvar g = 0; g < DRIVES; g++) begin : g_drive
    fmtc_drive u_drive (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (accept),
      .ctrl      (drv_ctrl[g]),
      .spin_up   (spin_up_r),
      .off_delay (off_delay_r),
      .hold      (hold_r),
      .stat      (drv_stat[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spin_up_r   <= fmtc_pkg::SPIN_UP_RESET;
      off_delay_r <= fmtc_pkg::OFF_DELAY_RESET;
      hold_r      <= fmtc_pkg::HOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        fmtc_pkg::CFG_SPIN_UP:   spin_up_r   <= cfg_wdata;
        fmtc_pkg::CFG_OFF_DELAY: off_delay_r <= cfg_wdata;
        fmtc_pkg::CFG_HOLD:      hold_r      <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r      <= fmtc_pkg::CONTROL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        ctrl_r      <= ctrl_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte_r    <= ctrl_nxt;
      out_written_r <= written;
      out_wake_r    <= wake;
      out_ticks_r   <= ready_ticks;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_control_byte    = out_byte_r;
  assign out_control_written = out_written_r;
  assign out_wake_mask       = out_wake_r;
  assign out_ready_ticks     = out_ticks_r;

`ifndef SYNTH
  a_ctrl_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !accept |=> ctrl_r == $past(ctrl_r))
    else $error("control byte changed without a request");

  a_select_on_only: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && accept && !cmd_on |=> ctrl_r[1:0] == $past(ctrl_r[1:0]))
    else $error("select bits changed outside a motor-on request");

  a_ticks_on_only: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && accept && !cmd_on |=> out_ready_ticks == 16'd0)
    else $error("ready ticks nonzero outside a motor-on request");

  a_wake_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_wake_mask & ~out_control_byte[7:4]) == 4'd0)
    else $error("wake for a motor that is off");
`endif

endmodule
